[rtl/ckx_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckx_pkg: shared types and constants
// ChaCha20 constants, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package ckx_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd4;

  localparam int unsigned ROUND_STEPS = 80;
  localparam int unsigned STEP_W = 7;
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
    logic       new_block;
  } ckx_entry_t;

  typedef logic [15:0][31:0] ckx_state_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage
`default_nettype wire

[rtl/ckx_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckx_stream_if: valid/ready channel
// Carries a data byte and the end of buffer marker.
// ----------------------------------------------------------------------------
interface ckx_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       eob;
  modport source (output valid, output data, output eob, input ready);
  modport sink (input valid, input data, input eob, output ready);
endinterface

interface ckx_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ckx_pkg::CFG_IDX_W-1:0] index;
  logic [ckx_pkg::CFG_DATA_W-1:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

[rtl/ckx_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckx_front: input stage and byte position tracking
// Accepts beats, tags the first byte of each block and pushes a queue entry.
// ----------------------------------------------------------------------------
module ckx_front (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  logic                restart,
  input  wire  logic                q_full,
  output ckx_pkg::ckx_entry_t       q_wdata,
  output logic                      q_push,
  ckx_stream_if.sink                in_ch
);

  logic [5:0] pos_r, pos_nxt;

  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && in_ch.ready;
  assign q_wdata = '{data: in_ch.data, eob: in_ch.eob, new_block: (pos_r == 6'd0)};

  always_comb begin
    pos_nxt = pos_r;
    if (restart) pos_nxt = 6'd0;
    else if (q_push) pos_nxt = pos_r + 6'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pos_r <= 6'd0;
    else pos_r <= pos_nxt;
  end

endmodule
`default_nettype wire

[rtl/ckx_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckx_queue: small fifo between front and back
// Two entries, push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ckx_queue (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  logic                push,
  input  ckx_pkg::ckx_entry_t       wdata,
  input  wire  logic                pop,
  output ckx_pkg::ckx_entry_t       rdata,
  output logic                      empty,
  output logic                      full
);

  ckx_pkg::ckx_entry_t mem_r [ckx_pkg::QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full = (cnt_r == 2'd2);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");

endmodule
`default_nettype wire

[rtl/ckx_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckx_back: keystream core and output stage
// Runs one quarter round per cycle for new blocks, xors bytes, holds result.
// ----------------------------------------------------------------------------
module ckx_back (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  logic [63:0]         key_low,
  input  wire  logic [63:0]         key_high,
  input  wire  logic [31:0]         init_ctr,
  input  wire  logic [63:0]         nonce_low,
  input  wire  logic [31:0]         nonce_high,
  input  wire  logic                restart,
  input  wire  logic                q_empty,
  input  ckx_pkg::ckx_entry_t       q_rdata,
  output logic                      q_pop,
  output logic                      busy,
  ckx_stream_if.source              out_ch
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ROUND = 3'b010,
    S_FIN   = 3'b100
  } bstate_t;

  bstate_t                      st_r, st_nxt;
  logic [31:0]                  ctr_r;
  ckx_pkg::ckx_state_t          in_w;
  ckx_pkg::ckx_state_t          w_r;
  logic [511:0]                 ks_r;
  logic [5:0]                   bpos_r;
  logic [ckx_pkg::STEP_W-1:0]   step_r;
  logic                         ov_r;
  logic [7:0]                   od_r;
  logic                         oe_r;
  logic                         out_free, take_byte, start_blk;
  logic                         head_first_r;
  logic [3:0]                   ia, ib, ic, id;
  logic [31:0]                  a1, d1, c1, b1, a2, d2, c2, b2;
  logic [2:0]                   qsel;
  ckx_pkg::ckx_state_t          w_qr, w_fin;

  assign in_w = {nonce_high, nonce_low[63:32], nonce_low[31:0], ctr_r,
                 ~key_high[63:32], ~key_high[31:0], ~key_low[63:32], ~key_low[31:0],
                 key_high[63:32], key_high[31:0], key_low[63:32], key_low[31:0],
                 ckx_pkg::SIGMA3, ckx_pkg::SIGMA2, ckx_pkg::SIGMA1, ckx_pkg::SIGMA0};

  assign qsel = step_r[2:0];
  always_comb begin
    unique case (qsel)
      3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
      3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
      3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
      3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
      3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
      3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
      3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
      default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
    endcase
    a1 = w_r[ia] + w_r[ib];
    d1 = ckx_pkg::rotl(w_r[id] ^ a1, 16);
    c1 = w_r[ic] + d1;
    b1 = ckx_pkg::rotl(w_r[ib] ^ c1, 12);
    a2 = a1 + b1;
    d2 = ckx_pkg::rotl(d1 ^ a2, 8);
    c2 = c1 + d2;
    b2 = ckx_pkg::rotl(b1 ^ c2, 7);
    w_qr = w_r;
    w_qr[ia] = a2;
    w_qr[ib] = b2;
    w_qr[ic] = c2;
    w_qr[id] = d2;
    for (int k = 0; k < 16; k++) w_fin[k] = w_r[k] + in_w[k];
  end

  assign out_free = !ov_r || out_ch.ready;
  assign start_blk = (st_r == S_IDLE) && !q_empty && q_rdata.new_block && !head_first_r;
  assign take_byte = (st_r == S_IDLE) && !q_empty && (!q_rdata.new_block || head_first_r)
                     && out_free;
  assign q_pop = take_byte;
  assign busy = (st_r != S_IDLE) || !q_empty || ov_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE:  if (start_blk) st_nxt = S_ROUND;
      S_ROUND: if (step_r == 7'(ckx_pkg::ROUND_STEPS - 1)) st_nxt = S_FIN;
      S_FIN:   st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ctr_r <= 32'd0;
      ov_r <= 1'b0;
      step_r <= '0;
      bpos_r <= 6'd0;
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (take_byte) begin
        ov_r <= 1'b1;
        bpos_r <= bpos_r + 6'd1;
      end
      if (restart) ctr_r <= init_ctr;
      else if (st_r == S_FIN) ctr_r <= ctr_r + 32'd1;
      if (start_blk) step_r <= '0;
      else if (st_r == S_ROUND) step_r <= step_r + 7'd1;
      if (st_r == S_FIN) bpos_r <= 6'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (start_blk) w_r <= in_w;
    else if (st_r == S_ROUND) w_r <= w_qr;
    if (st_r == S_FIN) ks_r <= w_fin;
    if (take_byte) begin
      od_r <= q_rdata.data ^ ks_r[{bpos_r, 3'b000} +: 8];
      oe_r <= q_rdata.eob;
    end
  end

  // the first byte of a block is held in the queue head until its block is ready
  always_ff @(posedge clk) begin
    if (!rst_n) head_first_r <= 1'b0;
    else if (st_r == S_FIN) head_first_r <= 1'b1;
    else if (take_byte) head_first_r <= 1'b0;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data = od_r;
  assign out_ch.eob = oe_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_ROUND |-> step_r < 7'(ckx_pkg::ROUND_STEPS)) else $error("step overrun");
  a_ctr_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_FIN && !restart) |=> ctr_r == $past(ctr_r) + 32'd1) else $error("counter");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> ov_r && $stable(od_r)) else $error("output lost");

endmodule
`default_nettype wire

[rtl/chacha20_keystream_xor_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chacha20_keystream_xor_unit: byte stream ChaCha20 xor
// Each input byte is xored with the next keystream byte. One byte per cycle
// within a 64-byte block while the output is not stalled; the first byte of
// each block waits while the shared quarter-round unit runs 80 steps (one
// quarter round per cycle) and the final add. A write to index 0-4 restarts it.
// ----------------------------------------------------------------------------
module chacha20_keystream_xor_unit (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ckx_stream_if.sink  in_ch,
  ckx_stream_if.source out_ch,
  ckx_cfg_if.sink     cfg_ch
);

  logic [63:0] key_low_r, key_high_r, nonce_low_r;
  logic [31:0] init_ctr_r, nonce_high_r;
  logic        restart, cfg_hit, q_push, q_pop, q_empty, q_full, busy;
  ckx_pkg::ckx_entry_t q_wdata, q_rdata;

  assign cfg_ch.ready = 1'b1;
  assign cfg_hit = cfg_ch.valid && (cfg_ch.index == ckx_pkg::REG_KEY_LOW
    || cfg_ch.index == ckx_pkg::REG_KEY_HIGH || cfg_ch.index == ckx_pkg::REG_INIT_CTR
    || cfg_ch.index == ckx_pkg::REG_NONCE_LOW || cfg_ch.index == ckx_pkg::REG_NONCE_HIGH);
  assign restart = cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r <= '0;
      key_high_r <= '0;
      init_ctr_r <= '0;
      nonce_low_r <= '0;
      nonce_high_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ckx_pkg::REG_KEY_LOW:    key_low_r <= cfg_ch.wdata;
        ckx_pkg::REG_KEY_HIGH:   key_high_r <= cfg_ch.wdata;
        ckx_pkg::REG_INIT_CTR:   init_ctr_r <= cfg_ch.wdata[31:0];
        ckx_pkg::REG_NONCE_LOW:  nonce_low_r <= cfg_ch.wdata;
        ckx_pkg::REG_NONCE_HIGH: nonce_high_r <= cfg_ch.wdata[31:0];
        default: ;
      endcase
    end
  end

  ckx_front u_front (
    .clk(clk), .rst_n(rst_n), .restart(restart), .q_full(q_full),
    .q_wdata(q_wdata), .q_push(q_push), .in_ch(in_ch)
  );

  ckx_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .empty(q_empty), .full(q_full)
  );

  ckx_back u_back (
    .clk(clk), .rst_n(rst_n), .key_low(key_low_r), .key_high(key_high_r),
    .init_ctr(restart && cfg_ch.index == ckx_pkg::REG_INIT_CTR ? cfg_ch.wdata[31:0]
              : init_ctr_r),
    .nonce_low(nonce_low_r), .nonce_high(nonce_high_r), .restart(restart),
    .q_empty(q_empty), .q_rdata(q_rdata), .q_pop(q_pop), .busy(busy), .out_ch(out_ch)
  );

  a_idle_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |-> !q_push) else $error("config during traffic");
  a_idle_back: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |-> !busy) else $error("config while busy");

endmodule
`default_nettype wire

[tb/sv/tb_chacha20_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_chacha20_checker: keystream predictor and output comparator
// Watches the config, input and output channels, keeps its own copy of the
// cipher state, predicts each output beat and compares it in order.
// ----------------------------------------------------------------------------
module tb_chacha20_checker (
  input  logic         clk,
  input  logic         rst_n,
  ckx_stream_if        in_ch,
  ckx_stream_if        out_ch,
  ckx_cfg_if           cfg,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       eob;
  } byte_beat_t;

  logic [63:0] key_lo, key_hi, nonce_lo;
  logic [31:0] ctr_init, nonce_hi, blk_ctr;
  logic [7:0]  ks [64];
  logic [5:0]  pos;
  byte_beat_t  expected_q [$];

  function automatic logic [31:0] rol(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  task automatic qr(inout logic [31:0] w [16], input int a, b, c, d);
    w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 16);
    w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 12);
    w[a] += w[b]; w[d] = rol(w[d] ^ w[a], 8);
    w[c] += w[d]; w[b] = rol(w[b] ^ w[c], 7);
  endtask

  task automatic gen_keystream_block();
    logic [31:0] init [16];
    logic [31:0] w [16];
    logic [31:0] v;
    init[0] = ckx_pkg::SIGMA0; init[1] = ckx_pkg::SIGMA1;
    init[2] = ckx_pkg::SIGMA2; init[3] = ckx_pkg::SIGMA3;
    init[4] = key_lo[31:0]; init[5] = key_lo[63:32];
    init[6] = key_hi[31:0]; init[7] = key_hi[63:32];
    for (int k = 0; k < 4; k++) init[8 + k] = ~init[4 + k];
    init[12] = blk_ctr;
    init[13] = nonce_lo[31:0]; init[14] = nonce_lo[63:32];
    init[15] = nonce_hi;
    w = init;
    for (int r = 0; r < 10; r++) begin
      qr(w, 0, 4, 8, 12); qr(w, 1, 5, 9, 13);
      qr(w, 2, 6, 10, 14); qr(w, 3, 7, 11, 15);
      qr(w, 0, 5, 10, 15); qr(w, 1, 6, 11, 12);
      qr(w, 2, 7, 8, 13); qr(w, 3, 4, 9, 14);
    end
    for (int k = 0; k < 16; k++) begin
      v = w[k] + init[k];
      for (int j = 0; j < 4; j++) ks[4 * k + j] = v[8 * j +: 8];
    end
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    byte_beat_t got, exp_b;
    if (!rst_n) begin
      key_lo = '0; key_hi = '0; nonce_lo = '0; ctr_init = '0; nonce_hi = '0;
      blk_ctr = '0; pos = '0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          ckx_pkg::REG_KEY_LOW:    key_lo = cfg.wdata;
          ckx_pkg::REG_KEY_HIGH:   key_hi = cfg.wdata;
          ckx_pkg::REG_INIT_CTR:   ctr_init = cfg.wdata[31:0];
          ckx_pkg::REG_NONCE_LOW:  nonce_lo = cfg.wdata;
          ckx_pkg::REG_NONCE_HIGH: nonce_hi = cfg.wdata[31:0];
          default: ;
        endcase
        if (cfg.index <= ckx_pkg::REG_NONCE_HIGH) begin
          blk_ctr = ctr_init;
          pos = '0;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (pos == 0) begin
          gen_keystream_block();
          blk_ctr++;
        end
        expected_q.push_back('{data: in_ch.data ^ ks[pos], eob: in_ch.eob});
        pos++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{data: out_ch.data, eob: out_ch.eob};
        if (expected_q.size() == 0) begin
          $error("unexpected output beat data=%h eob=%b", got.data, got.eob);
          fail_count++;
        end else begin
          exp_b = expected_q.pop_front();
          if (got.data !== exp_b.data) begin
            $error("data_out: expected %h actual %h", exp_b.data, got.data);
            fail_count++;
          end
          if (got.eob !== exp_b.eob) begin
            $error("end_of_buffer_out: expected %b actual %b", exp_b.eob, got.eob);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: chacha20_keystream_xor_unit testbench
// Drives register settings and byte streams with random idling and stalls;
// the checker predicts every output beat and reports mismatches.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   src_idle_pct = 0, snk_idle_pct = 0;
  bit   hold_sink = 1'b0;
  int   idle_cycles = 0;

  ckx_stream_if in_ch ();
  ckx_stream_if out_ch ();
  ckx_cfg_if    cfg ();

  chacha20_keystream_xor_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg)
  );

  tb_chacha20_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.data = '0; in_ch.eob = 1'b0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.wdata = '0;
  end

  always @(negedge clk) begin
    out_ch.ready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg.valid && cfg.ready) || hold_sink)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("chacha20_keystream_xor_unit: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [ckx_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg.valid <= 1'b1; cfg.index <= idx; cfg.wdata <= val;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send_byte(logic [7:0] d, logic e);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    in_ch.valid = 1'b1; in_ch.data = d; in_ch.eob = e;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic setup(logic [63:0] kl, kh, nl, logic [31:0] ic, nh);
    drain();
    write_reg(ckx_pkg::REG_KEY_LOW, kl);
    write_reg(ckx_pkg::REG_KEY_HIGH, kh);
    write_reg(ckx_pkg::REG_NONCE_LOW, nl);
    write_reg(ckx_pkg::REG_NONCE_HIGH, {32'h0, nh});
    write_reg(ckx_pkg::REG_INIT_CTR, {32'h0, ic});
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(199) == 0) setup({$urandom, $urandom}, {$urandom, $urandom},
          {$urandom, $urandom}, $urandom, $urandom);
      else if ($urandom_range(299) == 0) begin
        drain();
        write_reg(3'(ckx_pkg::REG_NONCE_HIGH + $urandom_range(1, 3)), {$urandom, $urandom});
      end
      send_byte($urandom, $urandom_range(7) == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // reset values, block crossing, extreme bytes
    send_byte(8'h00, 1'b0); send_byte(8'hff, 1'b1);
    for (int i = 0; i < 66; i++) send_byte(8'(i * 37), i[0]);
    // all ones with counter wrap
    setup('1, '1, '1, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 130; i++) send_byte(8'hff, 1'b1);
    // out of range index: no restart
    drain();
    write_reg(3'd7, '1);
    write_reg(3'd5, 64'h1234);
    for (int i = 0; i < 5; i++) send_byte(8'h5a, 1'b0);
    // single register rewrite restarts mid-block
    drain();
    write_reg(ckx_pkg::REG_INIT_CTR, 64'hffff_ffff_ffff_fffe);
    for (int i = 0; i < 10; i++) send_byte(8'h00, 1'b0);

    src_idle_pct = 34; snk_idle_pct = 77;
    random_run(300);
    src_idle_pct = 77; snk_idle_pct = 34;
    random_run(300);
    src_idle_pct = 0; snk_idle_pct = 0;
    random_run(200);

    // long receiver hold while input keeps coming
    fork
      begin
        hold_sink = 1'b1;
        repeat (300) @(posedge clk);
        hold_sink = 1'b0;
      end
      random_run(50);
    join
    // sender pause until all outputs are back
    drain();
    random_run(50);

    drain();
    if (fail_count == 0)
      $display("chacha20_keystream_xor_unit: match");
    else
      $display("chacha20_keystream_xor_unit: mismatch");
    $finish;
  end
endmodule

[files.f]
rtl/ckx_pkg.sv
rtl/ckx_stream_if.sv
rtl/ckx_front.sv
rtl/ckx_queue.sv
rtl/ckx_back.sv
rtl/chacha20_keystream_xor_unit.sv
tb/sv/tb_chacha20_checker.sv
tb/sv/tb_top.sv
